/* rtl/core/poa_pkg.sv */
package poa_pkg;

  localparam int unsigned SlotsDef  = 8;
  localparam int unsigned PidW      = 32;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned PsizeW    = 25;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned SlotOutW  = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned InDataW   = 96;
  localparam int unsigned OutDataW  = 40;

  typedef enum logic [CmdW-1:0] {
    CMD_CLAIM = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_RANGE = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_NEW       = 3'd0,
    STAT_OWNED     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_ZERO_PID  = 3'd3,
    STAT_CLEARED   = 3'd4,
    STAT_RANGE_OK  = 3'd5,
    STAT_RANGE_BAD = 3'd6
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ARENA_SIZE = 2'd0,
    CFG_PART_SIZE  = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } mem_ctrl_t;

endpackage

/* rtl/core/poa_owner_mem.sv */
module poa_owner_mem #(
  parameter int unsigned SLOTS = poa_pkg::SlotsDef,
  parameter int unsigned IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  poa_pkg::mem_ctrl_t        ctrl_i,
  input  logic [IDXW-1:0]           rd_addr_i,
  input  logic [IDXW-1:0]           wr_addr_i,
  input  logic [poa_pkg::PidW-1:0]  wr_data_i,
  output logic [poa_pkg::PidW-1:0]  rd_data_o
);

  logic [poa_pkg::PidW-1:0] mem_q [SLOTS];
  logic [SLOTS-1:0]         valid_q;
  logic [poa_pkg::PidW-1:0] rd_data_q;
  logic                     rd_vld_q;

  // entries without a valid bit read as free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        valid_q <= '0;
      end else if (ctrl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

/* rtl/core/poa_ctrl.sv */
module poa_ctrl #(
  parameter int unsigned SLOTS = poa_pkg::SlotsDef,
  parameter int unsigned IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [poa_pkg::AddrW-1:0]     arena_size_i,
  input  logic [poa_pkg::PsizeW-1:0]    part_size_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [poa_pkg::CmdW-1:0]      in_command_i,
  input  logic [poa_pkg::PidW-1:0]      in_pid_i,
  input  logic [poa_pkg::AddrW-1:0]     in_offset_i,
  input  logic [poa_pkg::AddrW-1:0]     in_length_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output poa_pkg::status_e              out_status_o,
  output logic [poa_pkg::SlotOutW-1:0]  out_slot_o,
  output logic [poa_pkg::AddrW-1:0]     out_part_offset_o,
  output poa_pkg::mem_ctrl_t            mem_ctrl_o,
  output logic [IDXW-1:0]               mem_rd_addr_o,
  output logic [IDXW-1:0]               mem_wr_addr_o,
  output logic [poa_pkg::PidW-1:0]      mem_wr_data_o,
  input  logic [poa_pkg::PidW-1:0]      mem_rd_data_i
);

  localparam int unsigned CNTW = $clog2(SLOTS + 1);
  localparam logic [IDXW-1:0] LastIdx = IDXW'(SLOTS - 1);

  poa_pkg::ctrl_state_e state_q, state_d;

  logic [CNTW-1:0]          issue_cnt_q;
  logic                     cmp_vld_q;
  logic [IDXW-1:0]          cmp_idx_q;
  logic                     have_free_q;
  logic [IDXW-1:0]          first_free_q;
  logic [poa_pkg::PidW-1:0] pid_q;

  poa_pkg::status_e         res_status_q;
  logic [IDXW-1:0]          res_slot_q;
  logic [poa_pkg::AddrW-1:0] res_off_q;

  logic                     out_valid_q;
  poa_pkg::status_e         out_status_q;
  logic [poa_pkg::SlotOutW-1:0] out_slot_q;
  logic [poa_pkg::AddrW-1:0] out_off_q;

  logic                     accept;
  logic                     issue;
  logic                     cmp_hit;
  logic                     cmp_free;
  logic                     cmp_last;
  logic                     free_now;
  logic [IDXW-1:0]          first_free;
  logic                     do_write;
  logic                     load_out;
  logic                     range_ok;
  logic [poa_pkg::AddrW-1:0] room;
  logic [poa_pkg::AddrW-1:0] mul_w;

  assign accept     = in_valid_i && in_ready_o;
  assign issue      = (state_q == poa_pkg::ST_SCAN) && (issue_cnt_q < CNTW'(SLOTS));
  assign cmp_hit    = cmp_vld_q && (mem_rd_data_i == pid_q);
  assign cmp_free   = cmp_vld_q && (mem_rd_data_i == '0);
  assign cmp_last   = cmp_vld_q && (cmp_idx_q == LastIdx);
  assign free_now   = have_free_q || cmp_free;
  assign first_free = have_free_q ? first_free_q : cmp_idx_q;
  assign do_write   = (state_q == poa_pkg::ST_SCAN) && !cmp_hit && cmp_last && free_now;
  assign load_out   = (state_q == poa_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  assign room     = arena_size_i - in_offset_i;
  assign range_ok = (in_offset_i <= arena_size_i) && (in_length_i <= room);
  assign mul_w    = 32'(res_slot_q) * 32'(part_size_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      poa_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_command_i)
            poa_pkg::CMD_CLAIM: state_d = (in_pid_i == '0) ? poa_pkg::ST_DONE
                                                           : poa_pkg::ST_SCAN;
            poa_pkg::CMD_CLEAR: state_d = poa_pkg::ST_DONE;
            poa_pkg::CMD_RANGE: state_d = poa_pkg::ST_DONE;
            default:            state_d = poa_pkg::ST_IDLE;
          endcase
        end
      end
      poa_pkg::ST_SCAN: begin
        if (cmp_hit || (cmp_last && free_now)) begin
          state_d = poa_pkg::ST_MUL;
        end else if (cmp_last) begin
          state_d = poa_pkg::ST_DONE;
        end
      end
      poa_pkg::ST_MUL:  state_d = poa_pkg::ST_DONE;
      poa_pkg::ST_DONE: if (load_out) state_d = poa_pkg::ST_IDLE;
      default:          state_d = poa_pkg::ST_IDLE;
    endcase
  end

  // outputs to the handshake and the owner memory
  always_comb begin
    in_ready_o       = 1'b0;
    mem_ctrl_o       = '0;
    mem_rd_addr_o    = issue_cnt_q[IDXW-1:0];
    mem_wr_addr_o    = first_free;
    mem_wr_data_o    = pid_q;
    case (state_q)
      poa_pkg::ST_IDLE: begin
        in_ready_o       = 1'b1;
        mem_ctrl_o.clear = in_valid_i && (in_command_i == poa_pkg::CMD_CLEAR);
      end
      poa_pkg::ST_SCAN: begin
        mem_ctrl_o.rd_en = issue;
        mem_ctrl_o.wr_en = do_write;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= poa_pkg::ST_IDLE;
      issue_cnt_q <= '0;
      cmp_vld_q   <= 1'b0;
      have_free_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == poa_pkg::ST_SCAN) begin
        cmp_vld_q <= issue;
        if (issue) begin
          issue_cnt_q <= issue_cnt_q + 1'b1;
        end
        if (cmp_free && !have_free_q) begin
          have_free_q <= 1'b1;
        end
      end else begin
        issue_cnt_q <= '0;
        cmp_vld_q   <= 1'b0;
        have_free_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (issue) begin
      cmp_idx_q <= issue_cnt_q[IDXW-1:0];
    end
    if ((state_q == poa_pkg::ST_SCAN) && cmp_free && !have_free_q) begin
      first_free_q <= cmp_idx_q;
    end
    case (state_q)
      poa_pkg::ST_IDLE: begin
        if (accept) begin
          pid_q      <= in_pid_i;
          res_slot_q <= '0;
          res_off_q  <= '0;
          case (in_command_i)
            poa_pkg::CMD_CLAIM: res_status_q <= poa_pkg::STAT_ZERO_PID;
            poa_pkg::CMD_CLEAR: res_status_q <= poa_pkg::STAT_CLEARED;
            poa_pkg::CMD_RANGE: res_status_q <= range_ok ? poa_pkg::STAT_RANGE_OK
                                                         : poa_pkg::STAT_RANGE_BAD;
            default:            res_status_q <= poa_pkg::STAT_ZERO_PID;
          endcase
        end
      end
      poa_pkg::ST_SCAN: begin
        if (cmp_hit) begin
          res_status_q <= poa_pkg::STAT_OWNED;
          res_slot_q   <= cmp_idx_q;
        end else if (cmp_last) begin
          res_status_q <= free_now ? poa_pkg::STAT_NEW : poa_pkg::STAT_FULL;
          res_slot_q   <= free_now ? first_free : '0;
        end
      end
      poa_pkg::ST_MUL: begin
        res_off_q <= mul_w;
      end
      default: begin
        res_off_q <= res_off_q;
      end
    endcase
    if (load_out) begin
      out_status_q <= res_status_q;
      out_slot_q   <= poa_pkg::SlotOutW'(res_slot_q);
      out_off_q    <= res_off_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_slot_o        = out_slot_q;
  assign out_part_offset_o = out_off_q;

`ifndef SYNTHESIS
  a_no_wr_and_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctrl_o.wr_en && mem_ctrl_o.clear))
    else $error("owner write and clear in the same cycle");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_cnt_q <= CNTW'(SLOTS))
    else $error("scan issued past the last slot");

  a_write_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctrl_o.wr_en |=> (state_q == poa_pkg::ST_MUL) && (res_status_q == poa_pkg::STAT_NEW))
    else $error("owner write without a new claim");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == poa_pkg::ST_DONE) && out_valid_q && !out_ready_i |=>
      (state_q == poa_pkg::ST_DONE))
    else $error("result left while the output register was full");
`endif

endmodule

/* rtl/core/partition_owner_allocator_unit.sv */
// Channel    Direction  Handshake                      Payload
// s_axis     in         s_axis_tvalid / s_axis_tready  tuser: command; tdata: pid, offset, length
// m_axis     out        m_axis_tvalid / m_axis_tready  tuser: status; tdata: slot, offset
// cfg        in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// One item at a time. A new claim goes from input to result transfer through
// one owner-memory read per slot (one read port, registered read data), the first-free
// write on the last compare, a multiply state and the output register.
// A hit ends the scan early; a full table skips the multiply state.
// Clear, range check and zero-pid claims go straight to the done state.
// Reset clears the per-slot valid bits at once, so no clearing pass is needed.
// A result waiting in the output register does not block the block; the next
// result stalls in the done state until the register is free.
module partition_owner_allocator_unit #(
  parameter int unsigned SLOTS = poa_pkg::SlotsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] pid, [63:32] offset, [95:64] length_bytes
  input  logic [poa_pkg::InDataW-1:0]    s_axis_tdata,
  // [1:0] command
  input  logic [poa_pkg::CmdW-1:0]       s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] slot, [34:3] partition_offset, [39:35] zero
  output logic [poa_pkg::OutDataW-1:0]   m_axis_tdata,
  // [2:0] status
  output logic [poa_pkg::StatusW-1:0]    m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [poa_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [poa_pkg::AddrW-1:0]      cfg_data_i
);

  localparam int unsigned IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [poa_pkg::AddrW-1:0]  arena_size_q;
  logic [poa_pkg::PsizeW-1:0] part_size_q;

  poa_pkg::mem_ctrl_t         mem_ctrl;
  logic [IDXW-1:0]            mem_rd_addr;
  logic [IDXW-1:0]            mem_wr_addr;
  logic [poa_pkg::PidW-1:0]   mem_wr_data;
  logic [poa_pkg::PidW-1:0]   mem_rd_data;

  poa_pkg::status_e           out_status;
  logic [poa_pkg::SlotOutW-1:0] out_slot;
  logic [poa_pkg::AddrW-1:0]  out_off;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_size_q <= '0;
      part_size_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        poa_pkg::CFG_ARENA_SIZE: arena_size_q <= cfg_data_i;
        poa_pkg::CFG_PART_SIZE:  part_size_q  <= cfg_data_i[poa_pkg::PsizeW-1:0];
        default:                 arena_size_q <= arena_size_q;
      endcase
    end
  end

  poa_owner_mem #(
    .SLOTS (SLOTS),
    .IDXW  (IDXW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mem_ctrl),
    .rd_addr_i (mem_rd_addr),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_data_o (mem_rd_data)
  );

  poa_ctrl #(
    .SLOTS (SLOTS),
    .IDXW  (IDXW)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .arena_size_i      (arena_size_q),
    .part_size_i       (part_size_q),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .in_command_i      (s_axis_tuser),
    .in_pid_i          (s_axis_tdata[31:0]),
    .in_offset_i       (s_axis_tdata[63:32]),
    .in_length_i       (s_axis_tdata[95:64]),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_status_o      (out_status),
    .out_slot_o        (out_slot),
    .out_part_offset_o (out_off),
    .mem_ctrl_o        (mem_ctrl),
    .mem_rd_addr_o     (mem_rd_addr),
    .mem_wr_addr_o     (mem_wr_addr),
    .mem_wr_data_o     (mem_wr_data),
    .mem_rd_data_i     (mem_rd_data)
  );

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {5'd0, out_off, out_slot};

endmodule

/* test/partition_owner_allocator_unit_test.sv */
`timescale 1ns / 1ps

module partition_owner_allocator_unit_test;

  localparam int unsigned Slots         = poa_pkg::SlotsDef;
  localparam int unsigned SettleCycles  = Slots + 8;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned PoolSize      = 12;
  localparam int unsigned MaxPsize      = 32'h0100_0000;
  localparam logic [poa_pkg::CmdW-1:0] CmdUnused = 2'd3;

  typedef struct {
    poa_pkg::status_e status;
    logic [2:0]       slot;
    logic [31:0]      poff;
  } alloc_result_t;

  class owner_table_scoreboard;
    logic [31:0]   owners [Slots];
    logic [31:0]   arena;
    logic [24:0]   psize;
    alloc_result_t pending [$];
    int unsigned   errors;

    function new();
      arena  = '0;
      psize  = '0;
      errors = 0;
      foreach (owners[i]) owners[i] = '0;
    endfunction

    function void write_reg(logic [poa_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        poa_pkg::CFG_ARENA_SIZE: arena = data;
        poa_pkg::CFG_PART_SIZE:  psize = data[24:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] slot_base(int unsigned s);
      logic [63:0] prod;
      prod = 64'(s) * 64'(psize);
      return prod[31:0];
    endfunction

    // first match wins; otherwise the lowest free slot is taken
    function void note_input(logic [poa_pkg::CmdW-1:0] cmd, logic [31:0] pid,
                             logic [31:0] off, logic [31:0] len);
      alloc_result_t r;
      int free_slot;
      bit hit;
      r.status  = poa_pkg::STAT_NEW;
      r.slot    = '0;
      r.poff    = '0;
      free_slot = -1;
      hit       = 1'b0;
      case (cmd)
        poa_pkg::CMD_CLAIM: begin
          if (pid == '0) begin
            r.status = poa_pkg::STAT_ZERO_PID;
          end else begin
            for (int i = 0; i < Slots && !hit; i++) begin
              if (owners[i] == pid) begin
                hit      = 1'b1;
                r.status = poa_pkg::STAT_OWNED;
                r.slot   = 3'(i);
                r.poff   = slot_base(i);
              end else if (owners[i] == '0 && free_slot < 0) begin
                free_slot = i;
              end
            end
            if (!hit) begin
              if (free_slot < 0) begin
                r.status = poa_pkg::STAT_FULL;
              end else begin
                owners[free_slot] = pid;
                r.status = poa_pkg::STAT_NEW;
                r.slot   = 3'(free_slot);
                r.poff   = slot_base(free_slot);
              end
            end
          end
        end
        poa_pkg::CMD_CLEAR: begin
          foreach (owners[i]) owners[i] = '0;
          r.status = poa_pkg::STAT_CLEARED;
        end
        poa_pkg::CMD_RANGE: begin
          if (off <= arena && len <= arena - off) r.status = poa_pkg::STAT_RANGE_OK;
          else r.status = poa_pkg::STAT_RANGE_BAD;
        end
        default: return;
      endcase
      pending.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      end
    endfunction

    function void check_result(logic [2:0] status, logic [2:0] slot, logic [31:0] poff);
      alloc_result_t e;
      if (pending.size() == 0) begin
        errors++;
        $error("unexpected result: status 0x%0h, slot 0x%0h, partition_offset 0x%0h",
               status, slot, poff);
        return;
      end
      e = pending.pop_front();
      compare("status", e.status, status);
      compare("slot", e.slot, slot);
      compare("partition_offset", e.poff, poff);
    endfunction
  endclass

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [poa_pkg::InDataW-1:0]   s_axis_tdata  = '0;
  logic [poa_pkg::CmdW-1:0]      s_axis_tuser  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [poa_pkg::OutDataW-1:0]  m_axis_tdata;
  logic [poa_pkg::StatusW-1:0]   m_axis_tuser;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [poa_pkg::CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [poa_pkg::AddrW-1:0]     cfg_data_i    = '0;

  owner_table_scoreboard sb = new();

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold_left = 0;
  int unsigned idle_cycles = 0;
  logic [31:0] cur_arena = '0;
  logic [31:0] pid_pool [PoolSize];

  partition_owner_allocator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // result sink; a long hold lets the block back up into its input
  initial forever begin
    @(posedge clk_i);
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // values read here are those from before the edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[34:3]);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_input(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                      s_axis_tdata[95:64]);
      if (cfg_valid_i && cfg_ready_o)
        sb.write_reg(cfg_index_i, cfg_data_i);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("partition_owner_allocator_unit_test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send(logic [poa_pkg::CmdW-1:0] cmd, logic [31:0] pid, logic [31:0] off,
                      logic [31:0] len);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {len, off, pid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // always waits on the clock before checking, so tvalid is never lowered and raised in one step
  task automatic wait_drained(int unsigned settle);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_config(logic [31:0] arena, logic [24:0] psize);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= poa_pkg::CFG_ARENA_SIZE;
    cfg_data_i  <= arena;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= poa_pkg::CFG_PART_SIZE;
    cfg_data_i  <= 32'(psize);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_arena = arena;
  endtask

  task automatic random_items(int unsigned n, int hold_at, int pause_at);
    logic [poa_pkg::CmdW-1:0] cmd;
    logic [31:0] pid, off, len, a;
    int unsigned done, r, p;
    bit held, paused;
    done   = 0;
    held   = 1'b0;
    paused = 1'b0;
    foreach (pid_pool[i]) pid_pool[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom;
    while (done < n) begin
      if (!held && done == hold_at) begin
        held = 1'b1;
        rx_hold_left = LongHold;
      end
      if (!paused && done == pause_at) begin
        paused = 1'b1;
        wait_drained(0);
      end
      a   = cur_arena;
      pid = $urandom;
      off = $urandom;
      len = $urandom;
      r   = $urandom_range(0, 99);
      if (r < 55) begin
        cmd = poa_pkg::CMD_CLAIM;
        p   = $urandom_range(0, 99);
        if (p < 70) pid = pid_pool[$urandom_range(0, PoolSize - 1)];
        else if (p < 80) pid = '0;
      end else if (r < 63) begin
        cmd = poa_pkg::CMD_CLEAR;
      end else if (r < 95) begin
        cmd = poa_pkg::CMD_RANGE;
        // half of the cases land on either side of the arena boundary
        case ($urandom_range(0, 3))
          0: ;
          1: begin
            off = $urandom_range(0, a);
            len = a - off + 32'($urandom_range(0, 2)) - 32'd1;
          end
          2: begin
            off = a + 32'($urandom_range(0, 2)) - 32'd1;
            len = $urandom_range(0, 2);
          end
          default: off = $urandom_range(0, 3);
        endcase
      end else begin
        cmd = CmdUnused;
      end
      send(cmd, pid, off, len);
      if (cmd != CmdUnused) done++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 34;
    rx_idle_pct = 56;
    write_config(32'd1000, 25'(MaxPsize));
    send(poa_pkg::CMD_CLAIM, 32'h0, '0, '0);
    send(poa_pkg::CMD_CLAIM, 32'hFFFF_FFFF, '0, '0);
    send(poa_pkg::CMD_CLAIM, 32'hFFFF_FFFF, '1, '1);
    for (int i = 1; i <= 7; i++) send(poa_pkg::CMD_CLAIM, 32'(i), '0, '0);
    send(poa_pkg::CMD_CLAIM, 32'd8, '0, '0);
    send(poa_pkg::CMD_CLAIM, 32'd5, '0, '0);
    send(CmdUnused, '1, '1, '1);
    send(poa_pkg::CMD_RANGE, '0, 32'd0, 32'd0);
    send(poa_pkg::CMD_RANGE, '0, 32'd1000, 32'd0);
    send(poa_pkg::CMD_RANGE, '0, 32'd1001, 32'd0);
    send(poa_pkg::CMD_RANGE, '0, 32'd0, 32'd1000);
    send(poa_pkg::CMD_RANGE, '0, 32'd0, 32'd1001);
    send(poa_pkg::CMD_RANGE, '0, 32'd500, 32'd500);
    send(poa_pkg::CMD_RANGE, '0, 32'd500, 32'd501);
    send(poa_pkg::CMD_RANGE, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // a naive sum would wrap and pass
    send(poa_pkg::CMD_RANGE, '0, 32'd1, 32'hFFFF_FFFF);
    send(poa_pkg::CMD_CLEAR, '1, '1, '1);
    send(poa_pkg::CMD_CLAIM, 32'h8000_0000, '0, '0);
    wait_drained(SettleCycles);

    write_config(32'hFFFF_FFFF, '0);
    random_items(450, -1, -1);
    wait_drained(SettleCycles);

    write_config(32'd0, 25'd1);
    random_items(250, 20, -1);
    wait_drained(SettleCycles);

    tx_idle_pct = 56;
    rx_idle_pct = 34;
    write_config($urandom, 25'($urandom_range(0, MaxPsize)));
    random_items(450, -1, -1);
    wait_drained(SettleCycles);

    write_config($urandom_range(0, 4096), 25'(MaxPsize));
    random_items(250, -1, 120);
    wait_drained(SettleCycles);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_config($urandom, 25'($urandom_range(0, MaxPsize)));
    random_items(600, -1, -1);
    wait_drained(SettleCycles);

    if (sb.errors == 0) begin
      $display("partition_owner_allocator_unit_test passed");
    end else begin
      $display("partition_owner_allocator_unit_test failed");
    end
    $finish;
  end

endmodule
